### design/mcss_pkg.sv
// Shared types and constants for the multiple-choice subset-sum core.
`default_nettype none
package mcss_pkg;

  localparam int SUM_SPAN = 256;
  localparam int SUM_W    = $clog2(SUM_SPAN);
  localparam int GRP_W    = 16;
  localparam int GRP_N    = SUM_SPAN / GRP_W;
  localparam int GRP_IW   = $clog2(GRP_W);
  localparam int GRP_NW   = $clog2(GRP_N);

  localparam int BUDGET_W = 8;
  localparam logic [BUDGET_W-1:0] BUDGET_RST = 8'd255;

  localparam logic signed [8:0] BEST_NONE = -9'sd1;

  typedef logic [SUM_SPAN-1:0] sum_set_t;

  typedef struct packed {
    logic [7:0] price;
    logic       last_in_class;
    logic       last_class;
    logic       empty_class;
  } in_word_t;

  typedef struct packed {
    logic signed [8:0] best_sum;
    logic              found;
  } out_word_t;

  // Control of one set update.
  typedef struct packed {
    logic fire;
    logic empty_class;
    logic class_end;
    logic last_class;
  } reach_ctl_t;

endpackage
`default_nettype wire

### design/mcss_reach_set.sv
// Reachable-sum sets and their shift-OR update.
`default_nettype none
module mcss_reach_set
  import mcss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire reach_ctl_t       ctl,
  input  wire logic [7:0]       price,
  input  wire logic [SUM_W-1:0] lim,
  output sum_set_t              final_set
);

  sum_set_t now_r, now_nxt;
  sum_set_t next_r, next_nxt;
  sum_set_t lim_mask;
  sum_set_t ext;
  sum_set_t next_upd;

  always_comb begin
    lim_mask = {SUM_SPAN{1'b1}} >> (SUM_W'(SUM_SPAN - 1) - lim);
    ext      = ((now_r & lim_mask) << price) & lim_mask;
    next_upd = ctl.empty_class ? '0 : (next_r | ext);
    // At class end the updated next set becomes the current set, or {0} after the last class.
    final_set = next_upd & lim_mask;
  end

  always_comb begin
    now_nxt  = now_r;
    next_nxt = next_r;
    if (ctl.fire) begin
      if (ctl.class_end) begin
        next_nxt = '0;
        now_nxt  = ctl.last_class ? SUM_SPAN'(1) : next_upd;
      end else begin
        next_nxt = next_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= SUM_SPAN'(1);
      next_r <= '0;
    end else begin
      now_r  <= now_nxt;
      next_r <= next_nxt;
    end
  end

endmodule
`default_nettype wire

### design/mcss_max_find.sv
// Two-level search for the highest set bit: registered group encoders, then group select.
`default_nettype none
module mcss_max_find
  import mcss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire sum_set_t         set_in,
  output logic [SUM_W-1:0]      best_idx,
  output logic                  found
);

  logic [GRP_N-1:0]             grp_any_r;
  logic [GRP_N-1:0][GRP_IW-1:0] grp_idx_r;
  logic [GRP_N-1:0]             grp_any_nxt;
  logic [GRP_N-1:0][GRP_IW-1:0] grp_idx_nxt;

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any_nxt[g] = |set_in[g*GRP_W +: GRP_W];
      grp_idx_nxt[g] = '0;
      // Ascending scan: the highest set bit is the last one to win.
      for (int b = 0; b < GRP_W; b++) begin
        if (set_in[g*GRP_W + b]) grp_idx_nxt[g] = GRP_IW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_any_r <= grp_any_nxt;
      grp_idx_r <= grp_idx_nxt;
    end
  end

  always_comb begin
    best_idx = '0;
    found    = |grp_any_r;
    for (int g = 0; g < GRP_N; g++) begin
      if (grp_any_r[g]) best_idx = {GRP_NW'(g), grp_idx_r[g]};
    end
  end

endmodule
`default_nettype wire

### design/multiple_choice_subset_sum_core.sv
// A word that closes the final class passes the input, group encoder and output registers.
// Throughput: one input word per cycle unless a result word waits for the search stage; the
// reachable-set update is one shift-OR per cycle. Words that give no result keep flowing while
// a result waits at the output register. Reset (synchronous, active low): reachable set {0},
// pending set empty, budget 255, no word in flight. No clearing pass is needed.
`default_nettype none
module multiple_choice_subset_sum_core
  import mcss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_word_t            in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_word_t                out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [BUDGET_W-1:0] cfg_data
);

  logic [BUDGET_W-1:0] budget_r;
  in_word_t            in_r;
  logic                v1_r, v1_nxt;
  logic                s2_v_r, s2_v_nxt;
  logic                out_v_r, out_v_nxt;
  out_word_t           out_r;

  logic                class_end;
  logic                s1_rslt;
  logic                o_free;
  logic                s2_free;
  logic                s1_fire;
  logic                s2_load;
  logic                out_load;
  logic [SUM_W-1:0]    lim;
  reach_ctl_t          ctl;
  sum_set_t            final_set;
  logic [SUM_W-1:0]    best_idx;
  logic                found;

  assign cfg_ready = 1'b1;

  always_comb begin
    lim = (budget_r > BUDGET_W'(SUM_SPAN - 1)) ? SUM_W'(SUM_SPAN - 1) : SUM_W'(budget_r);
    class_end = in_r.empty_class | in_r.last_in_class;
    s1_rslt   = class_end & in_r.last_class;
    o_free    = !out_v_r | out_ready;
    s2_free   = !s2_v_r | o_free;
    // Only a word that produces a result has to wait for the search stage.
    s1_fire   = v1_r & (!s1_rslt | s2_free);
    in_ready  = !v1_r | s1_fire;
    s2_load   = s1_fire & s1_rslt;
    out_load  = s2_v_r & o_free;

    v1_nxt    = in_ready ? in_valid : v1_r;
    s2_v_nxt  = s2_load ? 1'b1 : (o_free ? 1'b0 : s2_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

    ctl.fire        = s1_fire;
    ctl.empty_class = in_r.empty_class;
    ctl.class_end   = class_end;
    ctl.last_class  = in_r.last_class;
  end

  mcss_reach_set u_reach (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .price     (in_r.price),
    .lim       (lim),
    .final_set (final_set)
  );

  mcss_max_find u_find (
    .clk      (clk),
    .load     (s2_load),
    .set_in   (final_set),
    .best_idx (best_idx),
    .found    (found)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RST;
      v1_r     <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) budget_r <= cfg_data;
      v1_r    <= v1_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_word;
    if (out_load) begin
      out_r.found    <= found;
      out_r.best_sum <= found ? $signed({1'b0, best_idx}) : BEST_NONE;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

### design/mcss_checker.sv
// Port-level checks for the multiple-choice subset-sum core, bound to the top level.
`default_nettype none
module mcss_checker
  import mcss_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire out_word_t           out_word
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed or dropped while stalled");

  // The found flag agrees with the sign of the reported sum.
  a_found_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.found != out_word.best_sum[8]))
    else $error("found flag disagrees with best_sum");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // With the output side empty, the input side never stalls.
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind multiple_choice_subset_sum_core mcss_checker u_mcss_checker (.*);
`default_nettype wire
